/* rtl/oaht_pkg.sv */
package oaht_pkg;

    localparam logic [1:0] CMD_INSERT = 2'd0;
    localparam logic [1:0] CMD_SEARCH = 2'd1;
    localparam logic [1:0] CMD_DELETE = 2'd2;

    localparam logic [2:0] ST_NEW      = 3'd0;
    localparam logic [2:0] ST_UPDATED  = 3'd1;
    localparam logic [2:0] ST_FOUND    = 3'd2;
    localparam logic [2:0] ST_NOTFOUND = 3'd3;
    localparam logic [2:0] ST_DELETED  = 3'd4;
    localparam logic [2:0] ST_FULL     = 3'd5;

    localparam logic [1:0] MK_EMPTY = 2'd0;
    localparam logic [1:0] MK_USED  = 2'd1;
    localparam logic [1:0] MK_TOMB  = 2'd2;

    localparam int KEY_W = 32;
    localparam int VAL_W = 32;
    localparam int CNT_W = 11;

    typedef enum logic [4:0] {
        S_CLR,
        S_IDLE,
        S_DIV,
        S_PSTART,
        S_PADDR,
        S_PCHK,
        S_ACT,
        S_GTEST,
        S_GSQ,
        S_GMOD,
        S_WCLR,
        S_RADDR,
        S_RCHK,
        S_RHOME,
        S_DADDR,
        S_DCHK,
        S_RNEXT,
        S_FIN
    } state_t;

endpackage

/* rtl/oaht_if.sv */
interface oaht_cmd_if;
    import oaht_pkg::*;
    logic                    valid;
    logic                    ready;
    logic [1:0]              command;
    logic signed [KEY_W-1:0] key;
    logic [VAL_W-1:0]        value;
    modport source (output valid, command, key, value, input ready);
    modport sink (input valid, command, key, value, output ready);
endinterface

interface oaht_rsp_if;
    import oaht_pkg::*;
    logic             valid;
    logic             ready;
    logic [2:0]       status;
    logic [VAL_W-1:0] found_value;
    logic             grow_blocked;
    logic [CNT_W-1:0] table_capacity;
    logic [CNT_W-1:0] item_count;
    modport source (output valid, status, found_value, grow_blocked, table_capacity,
                    item_count, input ready);
    modport sink (input valid, status, found_value, grow_blocked, table_capacity,
                  item_count, output ready);
endinterface

/* rtl/open_addressing_hash_table.sv */
// open-addressing hash table with linear probing and tombstone deletion
// cmd channel: one item per command (insert or update, search, delete) with
// a signed key and a value handle; rsp channel: one item per command with
// status, found value, grow-blocked flag, capacity and item count
// a command is taken, its home-slot remainder is worked out one bit per
// cycle in the shared divider, the home slot is loaded, each probed slot
// is read through the registered read port, and the command is finished
// an insert that reaches three quarters load grows the table: the next
// prime is found by trial division on the same divider, the target bank
// is cleared one slot per cycle, and every old slot is read and each live
// entry rehashed; cmd.ready stays low until the rsp item is loaded
// after reset the slot marks of both banks, 2 * 2**clog2(MAX_SLOTS) slots,
// are cleared one per cycle, and cmd.ready stays low meanwhile
// the rsp item sits in an output register; a new command is taken while it
// waits, but that command's result holds until rsp.ready takes the old one
module open_addressing_hash_table #(
    parameter int MAX_SLOTS        = 1024,
    parameter int INITIAL_CAPACITY = 11
) (
    input  logic       clk,
    input  logic       rst_n,
    oaht_cmd_if.sink   cmd,
    oaht_rsp_if.source rsp
);
    import oaht_pkg::*;

    localparam int IW = $clog2(MAX_SLOTS);
    localparam int AW = IW + 1;
    localparam int CW = $clog2(MAX_SLOTS + 1);
    localparam int NW = $clog2(2 * MAX_SLOTS + 2);
    localparam int INIT_CAP = (INITIAL_CAPACITY > MAX_SLOTS) ? MAX_SLOTS : INITIAL_CAPACITY;

    function automatic logic [KEY_W-1:0] mag(input logic [KEY_W-1:0] v);
        return v[KEY_W-1] ? (~v + KEY_W'(1)) : v;
    endfunction

    state_t state_reg, state_next, ret_reg, ret_next;
    logic          bank_reg, bank_next;
    logic [CW-1:0] cap_reg, cap_next, occ_reg, occ_next, tomb_reg, tomb_next;
    logic [1:0]    cmd_reg, cmd_next;
    logic [KEY_W-1:0] key_reg, key_next, mkey_reg, mkey_next;
    logic [VAL_W-1:0] val_reg, val_next, mval_reg, mval_next;
    logic [IW-1:0] idx_reg, idx_next;
    logic [CW-1:0] n_reg, n_next, i_reg, i_next;
    logic [NW-1:0] newcap_reg, newcap_next, d_reg, d_next;
    logic [AW-1:0] clr_reg, clr_next;
    logic          pfound_reg, pfound_next, pused_reg, pused_next;
    logic [KEY_W-1:0] dvd_reg, dvd_next;
    logic [NW-1:0] dvs_reg, dvs_next, rem_reg, rem_next;
    logic [4:0]    dcnt_reg, dcnt_next;
    logic          neg_reg, neg_next;
    logic [2:0]    rst_reg, rst_next;
    logic [VAL_W-1:0] rfv_reg, rfv_next;
    logic          rgb_reg, rgb_next;
    logic          ov_reg, ov_next;
    logic [2:0]    ost_reg, ost_next;
    logic [VAL_W-1:0] ofv_reg, ofv_next;
    logic          ogb_reg, ogb_next;
    logic [CNT_W-1:0] ocap_reg, ocap_next, ocnt_reg, ocnt_next;

    logic [1:0]       mark_mem [2**AW];
    logic [KEY_W-1:0] key_mem [2**AW];
    logic [VAL_W-1:0] val_mem [2**AW];
    logic [1:0]       rd_mark;
    logic [KEY_W-1:0] rd_key;
    logic [VAL_W-1:0] rd_val;
    logic [AW-1:0]    rd_addr, wr_addr;
    logic             we_mark, we_key, we_val;
    logic [1:0]       wr_mark;
    logic [KEY_W-1:0] wr_key;
    logic [VAL_W-1:0] wr_val;

    logic [NW:0]   div_t;
    logic          div_ge;
    logic [NW-1:0] div_rs, div_fix;
    logic          div_last, probe_empty, probe_hit, probe_last, load_hit;
    logic          out_free, gsq_prime, rnext_last, clr_last, wclr_last;
    logic          cmd_bad;
    logic [CW+2:0] load_lhs, load_rhs;
    logic [2*NW-1:0] d_sq;

    assign div_t      = {rem_reg, dvd_reg[KEY_W-1]};
    assign div_ge     = div_t >= {1'b0, dvs_reg};
    assign div_rs     = div_ge ? NW'(div_t - {1'b0, dvs_reg}) : div_t[NW-1:0];
    assign div_fix    = (neg_reg && div_rs != '0) ? dvs_reg - div_rs : div_rs;
    assign div_last   = dcnt_reg == 5'd31;
    assign probe_empty = rd_mark == MK_EMPTY;
    assign probe_hit  = rd_mark == MK_USED && rd_key == key_reg;
    assign probe_last = n_reg + CW'(1) == cap_reg;
    assign load_lhs   = {(CW+1)'(occ_reg) + (CW+1)'(tomb_reg) + (CW+1)'(1), 2'b00};
    assign load_rhs   = (CW+3)'({cap_reg, 1'b0}) + (CW+3)'(cap_reg);
    assign load_hit   = load_lhs >= load_rhs;
    assign out_free   = !ov_reg || rsp.ready;
    assign d_sq       = d_reg * d_reg;
    assign gsq_prime  = d_sq > (2*NW)'(newcap_reg);
    assign rnext_last = i_reg + CW'(1) == cap_reg;
    assign clr_last   = &clr_reg;
    assign wclr_last  = NW'(idx_reg) + NW'(1) == newcap_reg;
    assign cmd_bad    = cmd.command != CMD_INSERT && cmd.command != CMD_SEARCH
                        && cmd.command != CMD_DELETE;

    always_comb
    begin
        unique case (state_reg)
            S_RADDR: rd_addr = {bank_reg, i_reg[IW-1:0]};
            S_DADDR: rd_addr = {~bank_reg, idx_reg};
            default: rd_addr = {bank_reg, idx_reg};
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (we_mark)
        begin
            mark_mem[wr_addr] <= wr_mark;
        end
        if (we_key)
        begin
            key_mem[wr_addr] <= wr_key;
        end
        if (we_val)
        begin
            val_mem[wr_addr] <= wr_val;
        end
        rd_mark <= mark_mem[rd_addr];
        rd_key  <= key_mem[rd_addr];
        rd_val  <= val_mem[rd_addr];
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_CLR:    if (clr_last) state_next = S_IDLE;
            S_IDLE:
            begin
                if (cmd.valid)
                begin
                    state_next = cmd_bad ? S_FIN : S_DIV;
                end
            end
            S_DIV:    if (div_last) state_next = ret_reg;
            S_PSTART: state_next = S_PADDR;
            S_PADDR:  state_next = S_PCHK;
            S_PCHK:
            begin
                if (probe_empty || probe_hit || probe_last)
                begin
                    state_next = S_ACT;
                end
                else
                begin
                    state_next = S_PADDR;
                end
            end
            S_ACT:
            begin
                if (cmd_reg == CMD_INSERT && pfound_reg && !pused_reg && load_hit)
                begin
                    state_next = S_GTEST;
                end
                else
                begin
                    state_next = S_FIN;
                end
            end
            S_GTEST:  state_next = (newcap_reg > NW'(MAX_SLOTS)) ? S_FIN : S_GSQ;
            S_GSQ:    state_next = gsq_prime ? S_WCLR : S_DIV;
            S_GMOD:   state_next = (rem_reg == '0) ? S_GTEST : S_GSQ;
            S_WCLR:   if (wclr_last) state_next = S_RADDR;
            S_RADDR:  state_next = S_RCHK;
            S_RCHK:   state_next = (rd_mark == MK_USED) ? S_DIV : S_RNEXT;
            S_RHOME:  state_next = S_DADDR;
            S_DADDR:  state_next = S_DCHK;
            S_DCHK:   state_next = (rd_mark == MK_USED) ? S_DADDR : S_RNEXT;
            S_RNEXT:  state_next = rnext_last ? S_FIN : S_RADDR;
            S_FIN:    if (out_free) state_next = S_IDLE;
            default:  state_next = S_IDLE;
        endcase
    end

    // datapath and memory control
    always_comb
    begin
        ret_next    = ret_reg;
        bank_next   = bank_reg;
        cap_next    = cap_reg;
        occ_next    = occ_reg;
        tomb_next   = tomb_reg;
        cmd_next    = cmd_reg;
        key_next    = key_reg;
        val_next    = val_reg;
        mkey_next   = mkey_reg;
        mval_next   = mval_reg;
        idx_next    = idx_reg;
        n_next      = n_reg;
        i_next      = i_reg;
        newcap_next = newcap_reg;
        d_next      = d_reg;
        clr_next    = clr_reg;
        pfound_next = pfound_reg;
        pused_next  = pused_reg;
        dvd_next    = dvd_reg;
        dvs_next    = dvs_reg;
        rem_next    = rem_reg;
        dcnt_next   = dcnt_reg;
        neg_next    = neg_reg;
        rst_next    = rst_reg;
        rfv_next    = rfv_reg;
        rgb_next    = rgb_reg;
        ov_next     = ov_reg && !rsp.ready;
        ost_next    = ost_reg;
        ofv_next    = ofv_reg;
        ogb_next    = ogb_reg;
        ocap_next   = ocap_reg;
        ocnt_next   = ocnt_reg;
        we_mark     = 1'b0;
        we_key      = 1'b0;
        we_val      = 1'b0;
        wr_addr     = {bank_reg, idx_reg};
        wr_mark     = MK_EMPTY;
        wr_key      = key_reg;
        wr_val      = val_reg;
        unique case (state_reg)
            S_CLR:
            begin
                we_mark  = 1'b1;
                wr_addr  = clr_reg;
                clr_next = clr_reg + AW'(1);
            end
            S_IDLE:
            begin
                cmd_next  = cmd.command;
                key_next  = cmd.key;
                val_next  = cmd.value;
                rst_next  = ST_NOTFOUND;
                rfv_next  = '0;
                rgb_next  = 1'b0;
                dvd_next  = mag(cmd.key);
                neg_next  = cmd.key[KEY_W-1];
                dvs_next  = NW'(cap_reg);
                rem_next  = '0;
                dcnt_next = '0;
                ret_next  = S_PSTART;
            end
            S_DIV:
            begin
                dvd_next  = {dvd_reg[KEY_W-2:0], 1'b0};
                dcnt_next = dcnt_reg + 5'd1;
                rem_next  = div_last ? div_fix : div_rs;
            end
            S_PSTART:
            begin
                idx_next = rem_reg[IW-1:0];
                n_next   = '0;
            end
            S_PCHK:
            begin
                pfound_next = probe_empty || probe_hit;
                pused_next  = probe_hit;
                if (!(probe_empty || probe_hit || probe_last))
                begin
                    n_next   = n_reg + CW'(1);
                    idx_next = (CW'(idx_reg) + CW'(1) == cap_reg) ? '0 : idx_reg + IW'(1);
                end
            end
            S_ACT:
            begin
                unique case (cmd_reg)
                    CMD_INSERT:
                    begin
                        if (!pfound_reg)
                        begin
                            rst_next = ST_FULL;
                        end
                        else if (pused_reg)
                        begin
                            we_val   = 1'b1;
                            rst_next = ST_UPDATED;
                        end
                        else
                        begin
                            we_mark     = 1'b1;
                            we_key      = 1'b1;
                            we_val      = 1'b1;
                            wr_mark     = MK_USED;
                            occ_next    = occ_reg + CW'(1);
                            rst_next    = ST_NEW;
                            newcap_next = NW'({cap_reg, 1'b0});
                        end
                    end
                    CMD_SEARCH:
                    begin
                        if (pused_reg)
                        begin
                            rfv_next = rd_val;
                            rst_next = ST_FOUND;
                        end
                    end
                    CMD_DELETE:
                    begin
                        if (pused_reg)
                        begin
                            we_mark   = 1'b1;
                            wr_mark   = MK_TOMB;
                            occ_next  = occ_reg - CW'(1);
                            tomb_next = tomb_reg + CW'(1);
                            rst_next  = ST_DELETED;
                        end
                    end
                    default: rst_next = ST_NOTFOUND;
                endcase
            end
            S_GTEST:
            begin
                d_next = NW'(2);
                if (newcap_reg > NW'(MAX_SLOTS))
                begin
                    rgb_next = 1'b1;
                end
            end
            S_GSQ:
            begin
                idx_next  = '0;
                dvd_next  = KEY_W'(newcap_reg);
                neg_next  = 1'b0;
                dvs_next  = d_reg;
                rem_next  = '0;
                dcnt_next = '0;
                ret_next  = S_GMOD;
            end
            S_GMOD:
            begin
                if (rem_reg == '0)
                begin
                    newcap_next = newcap_reg + NW'(1);
                end
                else
                begin
                    d_next = d_reg + NW'(1);
                end
            end
            S_WCLR:
            begin
                we_mark  = 1'b1;
                wr_addr  = {~bank_reg, idx_reg};
                idx_next = idx_reg + IW'(1);
                i_next   = '0;
            end
            S_RCHK:
            begin
                mkey_next = rd_key;
                mval_next = rd_val;
                dvd_next  = mag(rd_key);
                neg_next  = rd_key[KEY_W-1];
                dvs_next  = newcap_reg;
                rem_next  = '0;
                dcnt_next = '0;
                ret_next  = S_RHOME;
            end
            S_RHOME:  idx_next = rem_reg[IW-1:0];
            S_DCHK:
            begin
                if (rd_mark == MK_USED)
                begin
                    idx_next = (NW'(idx_reg) + NW'(1) == newcap_reg) ? '0 : idx_reg + IW'(1);
                end
                else
                begin
                    we_mark = 1'b1;
                    we_key  = 1'b1;
                    we_val  = 1'b1;
                    wr_addr = {~bank_reg, idx_reg};
                    wr_mark = MK_USED;
                    wr_key  = mkey_reg;
                    wr_val  = mval_reg;
                end
            end
            S_RNEXT:
            begin
                i_next = i_reg + CW'(1);
                if (rnext_last)
                begin
                    bank_next = ~bank_reg;
                    cap_next  = newcap_reg[CW-1:0];
                    tomb_next = '0;
                end
            end
            S_FIN:
            begin
                if (out_free)
                begin
                    ov_next   = 1'b1;
                    ost_next  = rst_reg;
                    ofv_next  = rfv_reg;
                    ogb_next  = rgb_reg;
                    ocap_next = CNT_W'(cap_reg);
                    ocnt_next = CNT_W'(occ_reg);
                end
            end
            default: ov_next = ov_reg && !rsp.ready;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLR;
            ret_reg   <= S_PSTART;
            bank_reg  <= 1'b0;
            cap_reg   <= CW'(INIT_CAP);
            occ_reg   <= '0;
            tomb_reg  <= '0;
            clr_reg   <= '0;
            dcnt_reg  <= '0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            ret_reg   <= ret_next;
            bank_reg  <= bank_next;
            cap_reg   <= cap_next;
            occ_reg   <= occ_next;
            tomb_reg  <= tomb_next;
            clr_reg   <= clr_next;
            dcnt_reg  <= dcnt_next;
            ov_reg    <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg    <= cmd_next;
        key_reg    <= key_next;
        val_reg    <= val_next;
        mkey_reg   <= mkey_next;
        mval_reg   <= mval_next;
        idx_reg    <= idx_next;
        n_reg      <= n_next;
        i_reg      <= i_next;
        newcap_reg <= newcap_next;
        d_reg      <= d_next;
        pfound_reg <= pfound_next;
        pused_reg  <= pused_next;
        dvd_reg    <= dvd_next;
        dvs_reg    <= dvs_next;
        rem_reg    <= rem_next;
        neg_reg    <= neg_next;
        rst_reg    <= rst_next;
        rfv_reg    <= rfv_next;
        rgb_reg    <= rgb_next;
        ost_reg    <= ost_next;
        ofv_reg    <= ofv_next;
        ogb_reg    <= ogb_next;
        ocap_reg   <= ocap_next;
        ocnt_reg   <= ocnt_next;
    end

    assign cmd.ready          = state_reg == S_IDLE;
    assign rsp.valid          = ov_reg;
    assign rsp.status         = ost_reg;
    assign rsp.found_value    = ofv_reg;
    assign rsp.grow_blocked   = ogb_reg;
    assign rsp.table_capacity = ocap_reg;
    assign rsp.item_count     = ocnt_reg;

`ifndef NO_ASSERTIONS
    a_load_bound: assert property (@(posedge clk) disable iff (!rst_n)
        ((CW+1)'(occ_reg) + (CW+1)'(tomb_reg)) <= (CW+1)'(cap_reg))
        else $error("occupied plus tombstones exceed capacity");
    a_cap_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cap_reg <= CW'(MAX_SLOTS))
        else $error("capacity above storage");
    a_fv_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && rsp.status != ST_FOUND |-> rsp.found_value == '0)
        else $error("found value set without a hit");
    a_gb_new: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && rsp.grow_blocked |-> rsp.status == ST_NEW)
        else $error("grow blocked on a command other than a new insert");
`endif

endmodule

/* tb/oaht_checker.sv */
module oaht_checker #(
    parameter int MAX_SLOTS        = 1024,
    parameter int INITIAL_CAPACITY = 11
) (
    input  logic clk,
    input  logic rst_n,
    oaht_cmd_if  cmd,
    oaht_rsp_if  rsp,
    output int   fail_count,
    output int   pending
);
    timeunit 1ns;
    timeprecision 1ps;
    import oaht_pkg::*;

    typedef struct packed {
        logic [2:0]       status;
        logic [VAL_W-1:0] found_value;
        logic             grow_blocked;
        logic [CNT_W-1:0] table_capacity;
        logic [CNT_W-1:0] item_count;
    } answer_t;

    logic [1:0]       marks [2*MAX_SLOTS];
    logic [KEY_W-1:0] keys  [2*MAX_SLOTS];
    logic [VAL_W-1:0] vals  [2*MAX_SLOTS];
    int unsigned      bank;
    int unsigned      cap;
    int unsigned      used_cnt;
    int unsigned      tomb_cnt;
    answer_t          answers_due [$];

    function automatic int unsigned home_slot(logic [KEY_W-1:0] k, int unsigned c);
        longint r;
        r = longint'($signed(k)) % longint'(c);
        if (r < 0)
            r += c;
        return int'(r);
    endfunction

    function automatic bit prime_check(int unsigned n);
        if (n < 2)
            return 0;
        for (int unsigned d = 2; d * d <= n; d++)
            if (n % d == 0)
                return 0;
        return 1;
    endfunction

    function automatic int probe_slot(logic [KEY_W-1:0] k);
        int unsigned base;
        int unsigned i;
        base = bank * MAX_SLOTS;
        i = home_slot(k, cap);
        for (int unsigned n = 0; n < cap; n++)
        begin
            if (marks[base+i] == MK_EMPTY)
                return i;
            if (marks[base+i] == MK_USED && keys[base+i] == k)
                return i;
            i = (i + 1 == cap) ? 0 : i + 1;
        end
        return -1;
    endfunction

    // returns 1 when growth is refused
    function automatic bit grow_table();
        int unsigned nc;
        int unsigned src;
        int unsigned dst;
        int unsigned j;
        nc = cap * 2;
        src = bank * MAX_SLOTS;
        dst = (bank ^ 1) * MAX_SLOTS;
        while (nc <= MAX_SLOTS && !prime_check(nc))
            nc++;
        if (nc > MAX_SLOTS)
            return 1;
        for (int unsigned i = 0; i < MAX_SLOTS; i++)
            marks[dst+i] = MK_EMPTY;
        for (int unsigned i = 0; i < cap; i++)
        begin
            if (marks[src+i] == MK_USED)
            begin
                j = home_slot(keys[src+i], nc);
                while (marks[dst+j] == MK_USED)
                    j = (j + 1 == nc) ? 0 : j + 1;
                marks[dst+j] = MK_USED;
                keys[dst+j] = keys[src+i];
                vals[dst+j] = vals[src+i];
            end
        end
        bank ^= 1;
        cap = nc;
        tomb_cnt = 0;
        return 0;
    endfunction

    function automatic answer_t apply_command(logic [1:0] c, logic [KEY_W-1:0] k,
                                              logic [VAL_W-1:0] v);
        answer_t a;
        int pos;
        int unsigned base;
        a = '0;
        a.status = ST_NOTFOUND;
        base = bank * MAX_SLOTS;
        if (c == CMD_INSERT || c == CMD_SEARCH || c == CMD_DELETE)
        begin
            pos = probe_slot(k);
            if (c == CMD_INSERT)
            begin
                if (pos < 0)
                    a.status = ST_FULL;
                else if (marks[base+pos] == MK_USED)
                begin
                    vals[base+pos] = v;
                    a.status = ST_UPDATED;
                end
                else
                begin
                    marks[base+pos] = MK_USED;
                    keys[base+pos] = k;
                    vals[base+pos] = v;
                    used_cnt++;
                    a.status = ST_NEW;
                    if ((used_cnt + tomb_cnt) * 4 >= cap * 3)
                        a.grow_blocked = grow_table();
                end
            end
            else if (pos >= 0 && marks[base+pos] == MK_USED)
            begin
                if (c == CMD_SEARCH)
                begin
                    a.found_value = vals[base+pos];
                    a.status = ST_FOUND;
                end
                else
                begin
                    marks[base+pos] = MK_TOMB;
                    used_cnt--;
                    tomb_cnt++;
                    a.status = ST_DELETED;
                end
            end
        end
        a.table_capacity = cap[CNT_W-1:0];
        a.item_count = used_cnt[CNT_W-1:0];
        return a;
    endfunction

    assign pending = answers_due.size();

    always @(posedge clk or negedge rst_n)
    begin
        answer_t got;
        answer_t want;
        if (!rst_n)
        begin
            for (int i = 0; i < 2 * MAX_SLOTS; i++)
                marks[i] = MK_EMPTY;
            bank = 0;
            cap = (INITIAL_CAPACITY > MAX_SLOTS) ? MAX_SLOTS : INITIAL_CAPACITY;
            used_cnt = 0;
            tomb_cnt = 0;
            answers_due.delete();
            fail_count <= 0;
        end
        else
        begin
            if (rsp.valid && rsp.ready)
            begin
                got = '{rsp.status, rsp.found_value, rsp.grow_blocked,
                        rsp.table_capacity, rsp.item_count};
                if (answers_due.size() == 0)
                begin
                    if (fail_count < 10)
                        $display("unexpected item on rsp: %p", got);
                    fail_count <= fail_count + 1;
                end
                else
                begin
                    want = answers_due.pop_front();
                    if (got.status !== want.status || got.found_value !== want.found_value ||
                        got.grow_blocked !== want.grow_blocked ||
                        got.table_capacity !== want.table_capacity ||
                        got.item_count !== want.item_count)
                    begin
                        if (fail_count < 10)
                            $display("rsp mismatch: expected %p got %p", want, got);
                        fail_count <= fail_count + 1;
                    end
                end
            end
            if (cmd.valid && cmd.ready)
                answers_due.push_back(apply_command(cmd.command, cmd.key, cmd.value));
        end
    end
endmodule

/* tb/open_addressing_hash_table_tb.sv */
module open_addressing_hash_table_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import oaht_pkg::*;

    localparam logic [1:0] CMD_UNUSED = 2'd3;
    localparam int IDLE_LIMIT = 400000;
    localparam int RANDOM_ITEMS = 1130;

    logic clk;
    logic rst_n;
    int   fail_count;
    int   pending;
    int   idle_cycles;
    bit   hold_req;
    bit   hold_done;
    int   burst_left;
    logic signed [31:0] key_pool [$];

    oaht_cmd_if cmd ();
    oaht_rsp_if rsp ();

    open_addressing_hash_table DUT (.clk(clk), .rst_n(rst_n), .cmd(cmd), .rsp(rsp));
    oaht_checker checker_i (.clk(clk), .rst_n(rst_n), .cmd(cmd), .rsp(rsp),
                            .fail_count(fail_count), .pending(pending));

    initial
    begin
        clk = 0;
        forever #1 clk = ~clk;
    end

    task automatic send_item(logic [1:0] c, logic signed [31:0] k, logic [31:0] v);
        cmd.valid <= 1'b1;
        cmd.command <= c;
        cmd.key <= k;
        cmd.value <= v;
        if (c == CMD_INSERT)
            key_pool.push_back(k);
        @(posedge clk);
        while (!cmd.ready)
            @(posedge clk);
        if (burst_left > 0)
            burst_left--;
        else
        begin
            cmd.valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clk);
            burst_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 40);
        end
    endtask

    function automatic logic signed [31:0] fresh_key();
        case ($urandom_range(0, 9))
            0: return $urandom_range(0, 60) - 30;
            1: return 32'sh8000_0000 + $urandom_range(0, 7);
            2: return 32'sh7fff_fff8 + $urandom_range(0, 7);
            default: return $urandom;
        endcase
    endfunction

    function automatic logic signed [31:0] old_key();
        if (key_pool.size() == 0)
            return fresh_key();
        return key_pool[$urandom_range(0, key_pool.size() - 1)];
    endfunction

    function automatic logic [31:0] rand_value();
        case ($urandom_range(0, 9))
            0: return 32'h0;
            1: return 32'hffff_ffff;
            default: return $urandom;
        endcase
    endfunction

    initial
    begin
        int r;
        int fresh_pct;
        int del_pct;
        rst_n = 1'b0;
        cmd.valid = 1'b0;
        cmd.command = CMD_INSERT;
        cmd.key = '0;
        cmd.value = '0;
        burst_left = 0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: extremes, collisions, tombstones, unused command, first growth
        send_item(CMD_SEARCH, 32'sd5, 32'h1234_5678);
        send_item(CMD_DELETE, 32'sd5, 32'h0);
        send_item(CMD_INSERT, 32'sh8000_0000, 32'hffff_ffff);
        send_item(CMD_INSERT, 32'sh7fff_ffff, 32'h0);
        send_item(CMD_INSERT, 32'sd0, 32'hdead_beef);
        send_item(CMD_INSERT, -32'sd1, 32'h5555_aaaa);
        send_item(CMD_INSERT, 32'sd11, 32'haaaa_5555);
        send_item(CMD_INSERT, 32'sd22, 32'h1);
        send_item(CMD_SEARCH, 32'sd22, 32'h0);
        send_item(CMD_SEARCH, 32'sd33, 32'h0);
        send_item(CMD_DELETE, 32'sd11, 32'h0);
        send_item(CMD_SEARCH, 32'sd22, 32'h0);
        send_item(CMD_INSERT, 32'sd22, 32'h2);
        send_item(CMD_INSERT, 32'sd11, 32'h3);
        send_item(CMD_UNUSED, 32'sh7fff_ffff, 32'hffff_ffff);
        send_item(CMD_SEARCH, 32'sh8000_0000, 32'h0);
        send_item(CMD_INSERT, -32'sd12, 32'h4);
        send_item(CMD_INSERT, 32'sd44, 32'h5);
        send_item(CMD_INSERT, 32'sd55, 32'h6);
        send_item(CMD_SEARCH, -32'sd1, 32'h0);
        send_item(CMD_DELETE, 32'sh7fff_ffff, 32'h0);
        send_item(CMD_DELETE, 32'sh7fff_ffff, 32'h0);

        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            if (n == 200)
                hold_req = 1;
            fresh_pct = (n < 880) ? 75 : 50;
            del_pct = (n < 880) ? 5 : 30;
            r = $urandom_range(0, 99);
            if (r < fresh_pct)
                send_item(CMD_INSERT, fresh_key(), rand_value());
            else if (r < fresh_pct + del_pct)
                send_item(CMD_DELETE, old_key(), rand_value());
            else if (r < 92)
                send_item(CMD_SEARCH, ($urandom_range(0, 3) == 0) ? fresh_key() : old_key(),
                          rand_value());
            else if (r < 97)
                send_item(CMD_INSERT, old_key(), rand_value());
            else
                send_item(CMD_UNUSED, fresh_key(), rand_value());
        end
        cmd.valid <= 1'b0;

        while (pending != 0)
            @(posedge clk);
        repeat (200) @(posedge clk);
        if (fail_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    initial
    begin
        int mode;
        rsp.ready = 1'b0;
        hold_done = 0;
        forever
        begin
            if (hold_req && !hold_done)
            begin
                rsp.ready <= 1'b0;
                repeat (600) @(posedge clk);
                hold_done = 1;
            end
            else
            begin
                mode = $urandom_range(0, 3);
                for (int i = 0; i < 64; i++)
                begin
                    case (mode)
                        0: rsp.ready <= 1'b1;
                        1: rsp.ready <= ($urandom_range(0, 3) == 0);
                        2: rsp.ready <= i[0];
                        default: rsp.ready <= ($urandom_range(0, 1) == 0);
                    endcase
                    @(posedge clk);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (cmd.valid && cmd.ready) || (rsp.valid && rsp.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
    end
endmodule
